// ===== rtl/core/rvme_pkg.sv =====
// ----------------------------------------------------------------------------
// rvme_pkg
// Shared types and constants of the register machine executor.
// ----------------------------------------------------------------------------
package rvme_pkg;

    localparam int unsigned POS_W     = 17;
    localparam int unsigned CAP_W     = 16;
    localparam int unsigned IDX_FW    = 8;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned IMM_W     = 16;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;
    localparam logic [POS_W-1:0] STEP_WORD = 17'd4;
    localparam logic [POS_W-1:0] STEP_BYTE = 17'd1;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_HALT    = 3'd5,
        CMD_ILLEGAL = 3'd6,
        CMD_UNREC   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HALT     = 3'd1,
        ST_ILLEGAL  = 3'd2,
        ST_UNRECOG  = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_DIVZERO  = 3'd5,
        ST_BADREG   = 3'd6,
        ST_STOPPED  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        K_LOAD,
        K_ARITH,
        K_END
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        t_kind              kind;
        logic               bad_reg;
        logic [IDX_FW-1:0]  first_reg;
        logic [IDX_FW-1:0]  second_reg;
        logic [IDX_FW-1:0]  dest_reg;
        logic [IMM_W-1:0]   immediate;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic               wrote;
        logic [IDX_FW-1:0]  written_index;
        logic [DATA_W-1:0]  written_value;
        logic [DATA_W-1:0]  remainder_value;
        logic [POS_W-1:0]   position;
    } t_result;

    typedef struct packed {
        logic   valid;
        logic   ready;
    } t_hs;

endpackage

// ===== rtl/core/rvme_cmd_if.sv =====
// ----------------------------------------------------------------------------
// rvme_cmd_if
// Decoded instruction channel: valid/ready with instruction fields.
// ----------------------------------------------------------------------------
interface rvme_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  first_reg;
    logic [7:0]  second_reg;
    logic [7:0]  dest_reg;
    logic [15:0] immediate;

    modport source (
        output valid, cmd, first_reg, second_reg, dest_reg, immediate,
        input  ready
    );
    modport sink (
        input  valid, cmd, first_reg, second_reg, dest_reg, immediate,
        output ready
    );
endinterface

// ===== rtl/core/rvme_res_if.sv =====
// ----------------------------------------------------------------------------
// rvme_res_if
// Result channel: valid/ready with execution status and write-back fields.
// ----------------------------------------------------------------------------
interface rvme_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        wrote;
    logic [7:0]  written_index;
    logic [31:0] written_value;
    logic [31:0] remainder_value;
    logic [16:0] position;

    modport source (
        output valid, status, wrote, written_index, written_value,
               remainder_value, position,
        input  ready
    );
    modport sink (
        input  valid, status, wrote, written_index, written_value,
               remainder_value, position,
        output ready
    );
endinterface

// ===== rtl/core/rvme_ram.sv =====
// ----------------------------------------------------------------------------
// rvme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvme_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/core/rvme_front.sv =====
// ----------------------------------------------------------------------------
// rvme_front
// Accepts instruction transactions, classifies them and checks indices.
// ----------------------------------------------------------------------------
module rvme_front #(
    parameter int unsigned REG_COUNT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rvme_cmd_if.sink         i_cmd,
    output logic             o_push,
    input  logic             i_push_ready,
    output rvme_pkg::t_entry o_entry
);
    import rvme_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   bad_a;
    logic   bad_b;
    logic   bad_d;

    assign bad_a = {1'b0, i_cmd.first_reg}  >= 9'(REG_COUNT);
    assign bad_b = {1'b0, i_cmd.second_reg} >= 9'(REG_COUNT);
    assign bad_d = {1'b0, i_cmd.dest_reg}   >= 9'(REG_COUNT);

    always_comb begin
        n_entry.cmd        = t_cmd'(i_cmd.cmd);
        n_entry.first_reg  = i_cmd.first_reg;
        n_entry.second_reg = i_cmd.second_reg;
        n_entry.dest_reg   = i_cmd.dest_reg;
        n_entry.immediate  = i_cmd.immediate;
        unique case (t_cmd'(i_cmd.cmd))
            CMD_LOAD: begin
                n_entry.kind    = K_LOAD;
                n_entry.bad_reg = bad_a;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                n_entry.kind    = K_ARITH;
                n_entry.bad_reg = bad_a | bad_b | bad_d;
            end
            default: begin
                n_entry.kind    = K_END;
                n_entry.bad_reg = 1'b0;
            end
        endcase
    end

    assign i_cmd.ready = !r_valid || i_push_ready;
    assign o_push      = r_valid;
    assign o_entry     = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_entry <= n_entry;
        end
    end
endmodule

// ===== rtl/core/rvme_fifo.sv =====
// ----------------------------------------------------------------------------
// rvme_fifo
// Short queue of classified instructions between front and back end.
// ----------------------------------------------------------------------------
module rvme_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  rvme_pkg::t_entry i_entry,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output rvme_pkg::t_entry o_entry
);
    import rvme_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = r_cnt != CNT_W'(FIFO_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_entry      = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("queue occupancy beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed a push");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");
endmodule

// ===== rtl/core/rvme_back.sv =====
// ----------------------------------------------------------------------------
// rvme_back
// Executes queued instructions on the register file; iterative divider.
// ----------------------------------------------------------------------------
module rvme_back #(
    parameter int unsigned REG_COUNT = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rvme_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  logic                            i_pop_valid,
    output logic                            o_pop,
    input  rvme_pkg::t_entry                i_entry,
    rvme_res_if.source                      o_res
);
    import rvme_pkg::*;

    localparam int unsigned IDX_W = $clog2(REG_COUNT);
    localparam int unsigned DCNT_W = $clog2(DIV_STEPS + 1);

    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap;
    logic                r_stopped, n_stopped;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [(1<<IDX_W)-1:0] r_vld;
    t_entry              r_ent, n_ent;
    logic                r_va, n_va;
    logic                r_vb, n_vb;
    logic [DATA_W-1:0]   r_dq, n_dq;
    logic [DATA_W-1:0]   r_dr, n_dr;
    logic [DATA_W-1:0]   r_dd, n_dd;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    t_result             res;
    logic                emit;
    logic                stop;
    logic                fire;
    logic                out_free;
    logic                rd_en;
    logic                wr_en;
    logic [DATA_W-1:0]   q_a;
    logic [DATA_W-1:0]   q_b;
    logic [DATA_W-1:0]   op_a;
    logic [DATA_W-1:0]   op_b;
    logic [DATA_W:0]     div_sh;
    logic [DATA_W:0]     div_diff;

    rvme_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (res.written_index[IDX_W-1:0]),
        .i_wdata (res.written_value),
        .i_re    (rd_en),
        .i_raddr (i_entry.first_reg[IDX_W-1:0]),
        .o_rdata (q_a)
    );

    rvme_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (res.written_index[IDX_W-1:0]),
        .i_wdata (res.written_value),
        .i_re    (rd_en),
        .i_raddr (i_entry.second_reg[IDX_W-1:0]),
        .o_rdata (q_b)
    );

    assign op_a     = r_va ? q_a : '0;
    assign op_b     = r_vb ? q_b : '0;
    assign out_free = !r_out_valid || o_res.ready;
    assign div_sh   = {r_dr, r_dq[DATA_W-1]};
    assign div_diff = div_sh - {1'b0, r_dd};

    always_comb begin
        n_state     = r_state;
        n_stopped   = r_stopped;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_ent       = r_ent;
        n_va        = r_va;
        n_vb        = r_vb;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_dd        = r_dd;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        emit        = 1'b0;
        stop        = 1'b0;

        res.status          = ST_OK;
        res.wrote           = 1'b0;
        res.written_index   = '0;
        res.written_value   = '0;
        res.remainder_value = r_rem;
        res.position        = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_ent   = i_entry;
                    n_va    = r_vld[i_entry.first_reg[IDX_W-1:0]];
                    n_vb    = r_vld[i_entry.second_reg[IDX_W-1:0]];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                emit = 1'b1;
                priority if (r_stopped) begin
                    res.status = ST_STOPPED;
                end else if (r_pos > {1'b0, r_cap}) begin
                    res.status = ST_OVERRUN;
                    stop       = 1'b1;
                end else if (r_ent.bad_reg) begin
                    res.status = ST_BADREG;
                    stop       = 1'b1;
                end else begin
                    unique case (r_ent.kind)
                        K_LOAD: begin
                            res.wrote         = 1'b1;
                            res.written_index = r_ent.first_reg;
                            res.written_value = {{(DATA_W-IMM_W){1'b0}}, r_ent.immediate};
                            res.position      = r_pos + STEP_WORD;
                        end
                        K_ARITH: begin
                            res.written_index = r_ent.dest_reg;
                            res.position      = r_pos + STEP_WORD;
                            res.wrote         = 1'b1;
                            unique case (r_ent.cmd)
                                CMD_ADD: res.written_value = op_a + op_b;
                                CMD_SUB: res.written_value = op_a - op_b;
                                CMD_MUL: res.written_value = op_a * op_b;
                                CMD_DIV: begin
                                    res.wrote         = 1'b0;
                                    res.written_index = '0;
                                    res.position      = r_pos;
                                    if (op_b == '0) begin
                                        res.status = ST_DIVZERO;
                                        stop       = 1'b1;
                                    end else begin
                                        emit    = 1'b0;
                                        n_dq    = op_a;
                                        n_dr    = '0;
                                        n_dd    = op_b;
                                        n_dcnt  = DCNT_W'(DIV_STEPS);
                                        n_state = S_DIV;
                                    end
                                end
                                default: res.wrote = 1'b0;
                            endcase
                        end
                        default: begin
                            res.position = r_pos + STEP_BYTE;
                            stop         = 1'b1;
                            unique case (r_ent.cmd)
                                CMD_HALT:    res.status = ST_HALT;
                                CMD_ILLEGAL: res.status = ST_ILLEGAL;
                                default:     res.status = ST_UNRECOG;
                            endcase
                        end
                    endcase
                end
            end
            default: begin
                if (r_dcnt != '0) begin
                    n_dcnt = r_dcnt - 1'b1;
                    if (!div_diff[DATA_W]) begin
                        n_dr = div_diff[DATA_W-1:0];
                        n_dq = {r_dq[DATA_W-2:0], 1'b1};
                    end else begin
                        n_dr = div_sh[DATA_W-1:0];
                        n_dq = {r_dq[DATA_W-2:0], 1'b0};
                    end
                end else begin
                    emit                = 1'b1;
                    res.wrote           = 1'b1;
                    res.written_index   = r_ent.dest_reg;
                    res.written_value   = r_dq;
                    res.remainder_value = r_dr;
                    res.position        = r_pos + STEP_WORD;
                end
            end
        endcase

        fire  = emit && out_free;
        wr_en = fire && res.wrote;
        if (fire) begin
            n_out       = res;
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
            n_stopped   = r_stopped | stop;
            n_pos       = res.position;
            n_rem       = res.remainder_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_stopped   <= 1'b0;
            r_pos       <= '0;
            r_rem       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stopped   <= n_stopped;
            r_pos       <= n_pos;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_vld[res.written_index[IDX_W-1:0]] <= 1'b1;
            end
        end
        r_ent  <= n_ent;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_dq   <= n_dq;
        r_dr   <= n_dr;
        r_dd   <= n_dd;
        r_dcnt <= n_dcnt;
        r_out  <= n_out;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out.status;
    assign o_res.wrote           = r_out.wrote;
    assign o_res.written_index   = r_out.written_index;
    assign o_res.written_value   = r_out.written_value;
    assign o_res.remainder_value = r_out.remainder_value;
    assign o_res.position        = r_out.position;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stopped) |-> (r_out_valid && r_out.status != ST_OK
                              && r_out.status != ST_STOPPED))
        else $error("stop without a reporting transaction");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_dcnt != '0)
            |=> (r_state == S_DIV && r_dcnt == $past(r_dcnt) - 1'b1))
        else $error("divider step lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.wrote) |-> (r_out.status == ST_OK))
        else $error("register write reported with an error status");
endmodule

// ===== rtl/core/register_vm_executor_unit.sv =====
// ----------------------------------------------------------------------------
// register_vm_executor_unit
// Executes decoded register machine instructions, one result per instruction.
//
// i_cmd carries one decoded instruction per transaction (valid/ready); o_res
// returns exactly one result transaction per instruction, in order.
// i_cfg_we/i_cfg_wdata write the program capacity; write only while idle.
// The front end registers and classifies each instruction and queues it
// (two entries); the back end reads both source operands from the register
// file RAMs (registered read) and executes.
// Load, add, sub, mul, halt and error cases pass through the idle and execute
// back-end states; the back end pops the next instruction only when idle.
// Divide adds the divide state, driven by the one-bit-per-cycle divider.
// A stalled o_res holds the result; the back end waits with the next result,
// while the queue and the front stage keep accepting until full.
// Synchronous reset clears the register file (per-entry valid bits), the
// remainder, the position and the stop flag, and sets capacity to 65535.
// ----------------------------------------------------------------------------
module register_vm_executor_unit #(
    parameter int unsigned REG_COUNT = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rvme_cmd_if.sink                    i_cmd,
    rvme_res_if.source                  o_res,
    input  logic                        i_cfg_we,
    input  logic [rvme_pkg::CAP_W-1:0]  i_cfg_wdata
);
    import rvme_pkg::*;

    logic   push;
    logic   push_ready;
    logic   pop_valid;
    logic   pop;
    t_entry push_entry;
    t_entry pop_entry;

    rvme_front #(.REG_COUNT(REG_COUNT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_entry      (push_entry)
    );

    rvme_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_entry      (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_entry      (pop_entry)
    );

    rvme_back #(.REG_COUNT(REG_COUNT)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pop_valid  (pop_valid),
        .o_pop        (pop),
        .i_entry      (pop_entry),
        .o_res        (o_res)
    );
endmodule
